/* sv/b2da_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

  // Fixed field widths
  localparam int INPUT_WIDTH = 32;
  localparam int DIGIT_BITS  = 4;
  localparam int CHAR_WIDTH  = 6;

  // ASCII '0' held in six bits
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 6'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE = 6'd57;

  // BCD adjust threshold and correction
  localparam logic [DIGIT_BITS-1:0] ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_BITS-1:0] ADJ_ADD   = 4'd3;

  // Sequencer to conversion unit
  typedef struct packed {
    logic start;
  } dab_ctrl_t;

  // Conversion unit back to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } dab_status_t;

endpackage

`default_nettype wire

/* sv/b2da_dabble.sv */
`timescale 1ns / 1ps
`default_nettype none

// Shift-and-add-3 converter: one bit of the binary value per cycle.
module b2da_dabble
  import b2da_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int NDIG  = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire dab_ctrl_t                  ctrl,
  input  wire logic [WIDTH-1:0]           value,
  output dab_status_t                     status,
  output logic [DIGIT_BITS*NDIG-1:0]      bcd
);

  localparam int CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]           bin;
  logic [CntW-1:0]            cnt;
  logic                       done;
  logic [DIGIT_BITS*NDIG-1:0] adjusted;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[d*DIGIT_BITS +: DIGIT_BITS] >= ADJ_LIMIT) begin
        adjusted[d*DIGIT_BITS +: DIGIT_BITS] = bcd[d*DIGIT_BITS +: DIGIT_BITS] + ADJ_ADD;
      end else begin
        adjusted[d*DIGIT_BITS +: DIGIT_BITS] = bcd[d*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  // Iteration counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (ctrl.start) begin
      cnt  <= CntW'(WIDTH);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CntW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: load, then shift one binary bit into the BCD word per cycle
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bin <= value;
      bcd <= '0;
    end else if (cnt != '0) begin
      bin <= bin << 1;
      bcd <= {adjusted[DIGIT_BITS*NDIG-2:0], bin[WIDTH-1]};
    end
  end

  assign status.busy = (cnt != '0);
  assign status.done = done;

endmodule

`default_nettype wire

/* sv/binary_to_decimal_ascii.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Signals                        Role
// -------  -----------------------------  ------------------------------------
// value    value_valid value_stall value  one binary number per request
// char     char_valid char_stall          one ASCII digit per transfer,
//          digit_char last_char           most significant first
//
// One request is accepted, then converted one bit per cycle over min(VALUE_WIDTH,32)
// bits through the shift-and-add-3 unit, handed over to the digit walk and
// walked one digit position per step (leading zeros are dropped, one per
// step); any output stall holds the walk.
// rst is synchronous and clears the sequencer and the output valid.
// value_stall stays high from acceptance until the final digit is loaded
// into the output register; char_stall holds the emit step.
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   value_valid,
  output logic                        value_stall,
  input  wire logic [INPUT_WIDTH-1:0] value,
  output logic                        char_valid,
  input  wire logic                   char_stall,
  output logic [CHAR_WIDTH-1:0]       digit_char,
  output logic                        last_char
);

  localparam int EffW  = (VALUE_WIDTH < INPUT_WIDTH) ? VALUE_WIDTH : INPUT_WIDTH;
  localparam int NDig  = (EffW * 30103) / 100000 + 1;
  localparam int BcdW  = DIGIT_BITS * NDig;
  localparam int LeftW = $clog2(NDig + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [BcdW-1:0]       digits;
  logic [LeftW-1:0]      left;
  logic                  seen_nz;
  logic [DIGIT_BITS-1:0] top_digit;
  logic                  slot_free;
  logic                  emit_now;
  logic                  is_last;
  logic                  in_accept;
  dab_ctrl_t             dab_ctrl;
  dab_status_t           dab_status;
  logic [BcdW-1:0]       dab_bcd;

  assign in_accept      = value_valid && !value_stall;
  assign value_stall    = (state != ST_IDLE);
  assign dab_ctrl.start = in_accept;

  b2da_dabble #(
    .WIDTH (EffW),
    .NDIG  (NDig)
  ) u_dabble (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (dab_ctrl),
    .value  (value[EffW-1:0]),
    .status (dab_status),
    .bcd    (dab_bcd)
  );

  // Emit step decode
  assign top_digit = digits[BcdW-1 -: DIGIT_BITS];
  assign slot_free = !char_valid || !char_stall;
  assign is_last   = (left == LeftW'(1));
  assign emit_now  = (top_digit != '0) || seen_nz || is_last;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (dab_status.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && is_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Digit walk: take the BCD word, then shift out one digit per step
  always_ff @(posedge clk) begin
    if (state == ST_CONV && dab_status.done) begin
      digits  <= dab_bcd;
      left    <= LeftW'(NDig);
      seen_nz <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      digits  <= digits << DIGIT_BITS;
      left    <= left - 1'b1;
      seen_nz <= seen_nz || (top_digit != '0);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free && emit_now) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free && emit_now) begin
      digit_char <= CHAR_ZERO + {{(CHAR_WIDTH-DIGIT_BITS){1'b0}}, top_digit};
      last_char  <= is_last;
    end
  end

  // Checks
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (digit_char >= CHAR_ZERO) && (digit_char <= CHAR_NINE))
    else $error("digit_char outside '0'..'9'");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    dab_status.busy |-> value_stall)
    else $error("request accepted while conversion unit busy");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    dab_status.done |-> (state == ST_CONV))
    else $error("conversion done outside conversion state");

  a_conv_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> (dab_status.busy || dab_status.done))
    else $error("conversion state with idle unit");

endmodule

`default_nettype wire
